FILE: src/avr_pkg.sv
// Shared types, constants and saturation helpers for the axis-angle rotator.
package avr_pkg;

  // Angle constants in Q4.28
  localparam logic signed [33:0] Q28_PI      = 34'sd843314857;
  localparam logic signed [33:0] Q28_HALF_PI = 34'sd421657428;
  localparam logic signed [33:0] Q28_TWO_PI  = 34'sd1686629713;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
  localparam logic signed [39:0] WIDE_LIMIT  = 40'sd8589934591;

  // Rounding offset for the Q30 product shift (half up)
  localparam logic signed [67:0] RND30 = 68'sd536870912;

  // atan(2^-i) in Q2.30
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
    32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
    32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
    32'd262144,    32'd131072,    32'd65536,     32'd32768,
    32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128,
    32'd64,        32'd32,        32'd16,        32'd8,
    32'd4,         32'd2,         32'd1,         32'd0
  };

  // What one CORDIC cell hands to the next
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               flip;
  } avr_rot_t;

  // Clamp to +-(2^33 - 1)
  function automatic logic signed [33:0] sat34(input logic signed [39:0] v);
    logic signed [39:0] t;
    t = v;
    if (v > WIDE_LIMIT) t = WIDE_LIMIT;
    if (v < -WIDE_LIMIT) t = -WIDE_LIMIT;
    return t[33:0];
  endfunction

  // Clamp to 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [39:0] t;
    t = v;
    if (v > 40'sd2147483647) t = 40'sd2147483647;
    if (v < -40'sd2147483648) t = -40'sd2147483648;
    return t[31:0];
  endfunction

  // Clamp to +-2^30
  function automatic logic signed [31:0] sat_one(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = v;
    if (v > Q30_ONE) t = Q30_ONE;
    if (v < -Q30_ONE) t = -Q30_ONE;
    return t[31:0];
  endfunction

endpackage

FILE: src/avr_cordic_cell.sv
// One rotation-mode CORDIC cell: a single micro-rotation and a register.
module avr_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              en,
  input  avr_pkg::avr_rot_t d_in,
  output avr_pkg::avr_rot_t d_out
);

  localparam logic signed [33:0] ATAN = 34'(avr_pkg::ATAN_Q30[IDX]);

  avr_pkg::avr_rot_t  cell_r;
  avr_pkg::avr_rot_t  cell_nxt;
  logic signed [33:0] xs;
  logic signed [33:0] ys;

  always_comb begin
    xs = d_in.x >>> IDX;
    ys = d_in.y >>> IDX;
    cell_nxt.flip = d_in.flip;
    if (!d_in.z[33]) begin
      cell_nxt.x = d_in.x - ys;
      cell_nxt.y = d_in.y + xs;
      cell_nxt.z = d_in.z - ATAN;
    end else begin
      cell_nxt.x = d_in.x + ys;
      cell_nxt.y = d_in.y - xs;
      cell_nxt.z = d_in.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_out = cell_r;

endmodule

FILE: src/avr_sincos.sv
// Angle folding, a row of CORDIC cells and the sign fix and clamp of cos/sin.
module avr_sincos #(
  parameter int STAGES = 24
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] angle,
  output logic signed [31:0] cos_q30,
  output logic signed [31:0] sin_q30
);

  logic signed [33:0] a0;
  logic signed [33:0] a1;
  logic signed [33:0] a2;
  logic signed [33:0] z4;
  logic               flip;
  avr_pkg::avr_rot_t  prep_r;
  avr_pkg::avr_rot_t  prep_nxt;
  avr_pkg::avr_rot_t  chain [STAGES+1];
  logic signed [33:0] fx;
  logic signed [33:0] fy;
  logic signed [31:0] cos_r;
  logic signed [31:0] sin_r;

  always_comb begin
    a0 = 34'(angle);
    if (a0 > avr_pkg::Q28_PI) begin
      a1 = a0 - avr_pkg::Q28_TWO_PI;
    end else if (a0 < -avr_pkg::Q28_PI) begin
      a1 = a0 + avr_pkg::Q28_TWO_PI;
    end else begin
      a1 = a0;
    end
    flip = 1'b0;
    a2   = a1;
    if (a1 > avr_pkg::Q28_HALF_PI) begin
      a2   = a1 - avr_pkg::Q28_PI;
      flip = 1'b1;
    end else if (a1 < -avr_pkg::Q28_HALF_PI) begin
      a2   = a1 + avr_pkg::Q28_PI;
      flip = 1'b1;
    end
    z4 = a2 <<< 2;
    prep_nxt.x    = avr_pkg::CORDIC_GAIN;
    prep_nxt.y    = '0;
    prep_nxt.z    = z4;
    prep_nxt.flip = flip;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_r <= prep_nxt;
    end
  end

  assign chain[0] = prep_r;

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    avr_cordic_cell #(.IDX(i)) u_cell (
      .clk   (clk),
      .en    (en),
      .d_in  (chain[i]),
      .d_out (chain[i+1])
    );
  end

  always_comb begin
    fx = chain[STAGES].flip ? -chain[STAGES].x : chain[STAGES].x;
    fy = chain[STAGES].flip ? -chain[STAGES].y : chain[STAGES].y;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= avr_pkg::sat_one(fx);
      sin_r <= avr_pkg::sat_one(fy);
    end
  end

  assign cos_q30 = cos_r;
  assign sin_q30 = sin_r;

endmodule

FILE: src/axis_angle_vector_rotation.sv
// Top level: Rodrigues rotation of a Q16.16 vector about a Q2.30 axis.
// Throughput: one vector per cycle; the whole pipeline advances together and
// holds while a result waits on out_tready. The CORDIC cell row sets the depth.
// Reset: synchronous, active low; clears the valid bits, datapath is not reset.
module axis_angle_vector_rotation #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle (32 bits each)
  input  logic [223:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_x, out_y, out_z (32 bits each)
  output logic [95:0]  out_tdata
);

  localparam int LAT = CORDIC_STAGES + 4;
  localparam int DLY = CORDIC_STAGES - 5;

  logic           en;
  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] vld_nxt;

  logic signed [31:0] cos_q30;
  logic signed [31:0] sin_q30;

  // Delay line for vector and axis, aligning the vector math with the CORDIC
  logic [191:0] dl_r [DLY];

  logic signed [31:0] v1_v_r [3];
  logic signed [31:0] v1_a_r [3];
  logic signed [63:0] v2_p_r [3];
  logic signed [31:0] v2_v_r [3];
  logic signed [31:0] v2_a_r [3];
  logic signed [35:0] v3_dot_r;
  logic signed [35:0] v3_dot_nxt;
  logic signed [31:0] v3_v_r [3];
  logic signed [31:0] v3_a_r [3];
  logic signed [67:0] v4_q_r [3];
  logic signed [31:0] v4_v_r [3];
  logic signed [31:0] v4_a_r [3];
  logic signed [37:0] v5_d_r [3];
  logic signed [33:0] v5_r_r [3];
  logic signed [31:0] v5_a_r [3];
  logic signed [65:0] v6_mp_r [3];
  logic signed [65:0] v6_mn_r [3];
  logic signed [37:0] v6_d_r [3];
  logic signed [33:0] v6_r_r [3];
  logic signed [37:0] v7_d_r [3];
  logic signed [33:0] v7_r_r [3];
  logic signed [33:0] v7_c_r [3];
  logic signed [37:0] v8_d_r [3];
  logic signed [65:0] v8_pc_r [3];
  logic signed [65:0] v8_ps_r [3];
  logic signed [31:0] out_r [3];

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_comb begin
    vld_nxt = {vld_r[LAT-2:0], in_tvalid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  assign out_tvalid = vld_r[LAT-1];

  avr_sincos #(.STAGES(CORDIC_STAGES)) u_sincos (
    .clk     (clk),
    .en      (en),
    .angle   (in_tdata[223:192]),
    .cos_q30 (cos_q30),
    .sin_q30 (sin_q30)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dl_r[0] <= in_tdata[191:0];
      for (int k = 1; k < DLY; k++) begin
        dl_r[k] <= dl_r[k-1];
      end
    end
  end

  always_comb begin
    v3_dot_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      v3_dot_nxt = v3_dot_nxt + 36'(signed'(68'(v2_p_r[i]) + avr_pkg::RND30) >>> 30);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v3_dot_r <= v3_dot_nxt;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_comp
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    logic signed [31:0] a_raw;
    logic signed [33:0] a_sat;
    logic signed [67:0] t_d;
    logic signed [39:0] r_full;
    logic signed [67:0] t_mp;
    logic signed [67:0] t_mn;
    logic signed [39:0] c_full;
    logic signed [67:0] t_pc;
    logic signed [67:0] t_ps;
    logic signed [39:0] sum;

    always_comb begin
      a_raw  = dl_r[DLY-1][96+32*i +: 32];
      a_sat  = 34'(avr_pkg::sat_one(34'(a_raw)));
      t_d    = v4_q_r[i] + avr_pkg::RND30;
      r_full = 40'(v4_v_r[i]) - 40'(signed'(t_d[67:30]));
      t_mp   = 68'(v6_mp_r[i]) + avr_pkg::RND30;
      t_mn   = 68'(v6_mn_r[i]) + avr_pkg::RND30;
      c_full = 40'(signed'(t_mp[67:30])) - 40'(signed'(t_mn[67:30]));
      t_pc   = 68'(v8_pc_r[i]) + avr_pkg::RND30;
      t_ps   = 68'(v8_ps_r[i]) + avr_pkg::RND30;
      sum    = 40'(v8_d_r[i]) + 40'(signed'(t_pc[67:30])) + 40'(signed'(t_ps[67:30]));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v1_v_r[i]  <= dl_r[DLY-1][32*i +: 32];
        v1_a_r[i]  <= a_sat[31:0];
        v2_p_r[i]  <= v1_a_r[i] * v1_v_r[i];
        v2_v_r[i]  <= v1_v_r[i];
        v2_a_r[i]  <= v1_a_r[i];
        v3_v_r[i]  <= v2_v_r[i];
        v3_a_r[i]  <= v2_a_r[i];
        v4_q_r[i]  <= v3_a_r[i] * v3_dot_r;
        v4_v_r[i]  <= v3_v_r[i];
        v4_a_r[i]  <= v3_a_r[i];
        v5_d_r[i]  <= t_d[67:30];
        v5_r_r[i]  <= avr_pkg::sat34(r_full);
        v5_a_r[i]  <= v4_a_r[i];
        v6_mp_r[i] <= v5_a_r[J] * v5_r_r[K];
        v6_mn_r[i] <= v5_a_r[K] * v5_r_r[J];
        v6_d_r[i]  <= v5_d_r[i];
        v6_r_r[i]  <= v5_r_r[i];
        v7_c_r[i]  <= avr_pkg::sat34(c_full);
        v7_d_r[i]  <= v6_d_r[i];
        v7_r_r[i]  <= v6_r_r[i];
        v8_pc_r[i] <= v7_r_r[i] * cos_q30;
        v8_ps_r[i] <= v7_c_r[i] * sin_q30;
        v8_d_r[i]  <= v7_d_r[i];
        out_r[i]   <= avr_pkg::sat32(sum);
      end
    end

    assign out_tdata[32*i +: 32] = out_r[i];
  end

endmodule

FILE: src/avr_checker.sv
// Port-level checks on the rotator's stream handshakes, bound to the top level.
module avr_assert (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata
);

  // A held result keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Input is taken exactly when the output slot frees up
  a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow output slot");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("not ready after reset");

endmodule

bind axis_angle_vector_rotation avr_assert u_avr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/avr_checker.sv
// Checker for the axis-angle rotator: predicts each rotated vector and compares results.
`timescale 1ns / 100ps
module avr_checker #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [223:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [95:0]  out_tdata,
  output int           fail_count,
  output int           pending
);

  localparam longint PI_Q28      = 64'sd843314857;
  localparam longint HALF_PI_Q28 = 64'sd421657428;
  localparam longint TWO_PI_Q28  = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam longint GAIN_Q30    = 64'sd652032874;
  localparam longint TERM_LIMIT  = 64'sd8589934591;

  localparam longint ARCTAN [32] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
    8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};

  logic [95:0] rotated_q[$];

  // arithmetic shift on longint floors for negatives
  function automatic longint round_q30(longint p);
    return (p + 64'sd536870912) >>> 30;
  endfunction

  function automatic longint limit(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic logic [95:0] rotate_vector(logic [223:0] item);
    longint v[3], a[3], d[3], r[3], cr[3];
    longint dot, ang, x, y, z, xs, ys, cs, sn;
    logic flip;
    logic [95:0] res;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      v[i] = longint'($signed(item[32*i +: 32]));
      a[i] = limit(longint'($signed(item[32*(i+3) +: 32])), ONE_Q30);
    end
    for (int i = 0; i < 3; i++) dot += round_q30(a[i] * v[i]);
    for (int i = 0; i < 3; i++) begin
      d[i] = round_q30(a[i] * dot);
      r[i] = limit(v[i] - d[i], TERM_LIMIT);
    end
    for (int i = 0; i < 3; i++)
      cr[i] = limit(round_q30(a[(i+1)%3] * r[(i+2)%3]) -
                    round_q30(a[(i+2)%3] * r[(i+1)%3]), TERM_LIMIT);
    ang = longint'($signed(item[192 +: 32]));
    flip = 1'b0;
    if (ang > PI_Q28) ang -= TWO_PI_Q28;
    else if (ang < -PI_Q28) ang += TWO_PI_Q28;
    if (ang > HALF_PI_Q28) begin
      ang -= PI_Q28;
      flip = 1'b1;
    end else if (ang < -HALF_PI_Q28) begin
      ang += PI_Q28;
      flip = 1'b1;
    end
    z = ang * 4;
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ARCTAN[i];
      end else begin
        x += ys; y -= xs; z += ARCTAN[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cs = limit(x, ONE_Q30);
    sn = limit(y, ONE_Q30);
    for (int i = 0; i < 3; i++)
      res[32*i +: 32] = clip32(d[i] + round_q30(r[i] * cs) + round_q30(cr[i] * sn));
    return res;
  endfunction

  always @(posedge clk) begin
    logic [95:0] want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready) rotated_q.push_back(rotate_vector(in_tdata));
      if (out_tvalid && out_tready) begin
        if (rotated_q.size() == 0) begin
          $error("result transfer with nothing expected: %h", out_tdata);
          errs = errs + 1;
        end else begin
          want = rotated_q.pop_front();
          for (int i = 0; i < 3; i++)
            if (want[32*i +: 32] !== out_tdata[32*i +: 32]) begin
              $error("out_%s expected %0d got %0d", i == 0 ? "x" : i == 1 ? "y" : "z",
                     $signed(want[32*i +: 32]), $signed(out_tdata[32*i +: 32]));
              errs = errs + 1;
            end
        end
      end
      if (errs > 0) fail_count <= fail_count + errs;
    end
  end

  assign pending = rotated_q.size();

endmodule

FILE: tb/tb_top.sv
// Testbench top: drives vectors into the rotator and gives the verdict.
`timescale 1ns / 100ps
module tb_top;

  localparam int N_RANDOM = 600;
  localparam longint CYCLE_LIMIT = 200000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [223:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;
  int           fail_count;
  int           pending;
  longint       cycles;
  logic         stim_done;

  axis_angle_vector_rotation #(.CORDIC_STAGES(24)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  avr_checker #(.CORDIC_STAGES(24)) u_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] rand_axis();
    case ($urandom_range(0, 4))
      0: return 32'h4000_0000;
      1: return 32'hC000_0000;
      2: return $urandom();  // may lie beyond unit range, which gets clamped
      default: return $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return {{14{$urandom_range(0, 1) == 1}}, 18'($urandom())};
      default: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
    endcase
  endfunction

  // one transfer after a random gap; valid stays high across back-to-back items
  task automatic send_vector(logic [223:0] item);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= item;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // result-side stalls
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    logic [31:0] ext [6];
    logic [31:0] ang [8];
    ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0001_0000, 32'hFFFF_0000,
            32'h4000_0000};
    ang = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd843314857, 32'd843314858,
            32'd421657428, 32'd421657429, -32'sd421657429, -32'sd843314858};
    in_tvalid = 1'b0;
    in_tdata  = '0;
    rst_n     = 1'b0;
    stim_done = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extreme components, unit and oversized axes, fold boundaries
    for (int i = 0; i < 8; i++)
      send_vector({ang[i], 32'h4000_0000, 32'h0, 32'h0, ext[i % 6], ext[(i+1) % 6],
                   ext[(i+2) % 6]});
    send_vector({32'h1000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
    send_vector({32'h0, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_vector({32'hF000_0000, 32'hC000_0000, 32'h0, 32'h2D41_3CCD,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000});
    send_vector({32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h0});
    send_vector('1);
    send_vector('0);
    for (int n = 0; n < N_RANDOM; n++)
      send_vector({32'($urandom()), rand_axis(), rand_axis(), rand_axis(),
                   rand_comp(), rand_comp(), rand_comp()});
    in_tvalid <= 1'b0;
    stim_done <= 1'b1;
  end

  initial begin
    cycles = 0;
    @(posedge clk);
    while (!(stim_done && pending == 0) && cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("[axis_angle_vector_rotation] ERROR");
    end else begin
      repeat (40) @(posedge clk);
      if (fail_count == 0) begin
        $display("[axis_angle_vector_rotation] OK");
      end else begin
        $display("[axis_angle_vector_rotation] ERROR");
      end
    end
    $finish;
  end

endmodule

FILE: files.f
src/avr_pkg.sv
src/avr_cordic_cell.sv
src/avr_sincos.sv
src/axis_angle_vector_rotation.sv
src/avr_checker.sv
tb/avr_checker.sv
tb/tb_top.sv
